// ===== rtl/ndsaw_pkg.sv =====
// ----------------------------------------------------------------------------
// ndsaw_pkg
// Shared widths, register codes and helpers for the strided address walker.
// ----------------------------------------------------------------------------
package ndsaw_pkg;

  localparam int unsigned NumDims   = 4;
  localparam int unsigned SizeW     = 13;
  localparam int unsigned StepW     = 24;
  localparam int unsigned CntW      = 12;
  localparam int unsigned OfsW      = 38;
  localparam int unsigned IdxW      = 48;
  localparam int unsigned ProdW     = StepW + SizeW;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 32;
  localparam logic [SizeW-1:0] MaxSize = SizeW'(4096);

  typedef enum logic [2:0] {
    RegSizeDim0 = 3'd0,
    RegSizeDim1 = 3'd1,
    RegSizeDim2 = 3'd2,
    RegSizeDim3 = 3'd3,
    RegStepDim0 = 3'd4,
    RegStepDim1 = 3'd5,
    RegStepDim2 = 3'd6,
    RegStepDim3 = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [NumDims-1:0][SizeW-1:0] size;
    logic [NumDims-1:0][StepW-1:0] step;
    logic [NumDims-1:0][OfsW-1:0]  wrap;
  } walk_cfg_t;

  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] raw);
    logic [SizeW-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = SizeW'(1);
    end else if (raw > MaxSize) begin
      res = MaxSize;
    end
    return res;
  endfunction

endpackage

// ===== rtl/ndsaw_cfg.sv =====
// ----------------------------------------------------------------------------
// ndsaw_cfg
// Register file for sizes and steps; keeps the per-dimension wrap delta
// (step minus step times size) ready for the walker.
// ----------------------------------------------------------------------------
module ndsaw_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ndsaw_pkg::AddrW-1:0] paddr,
  input  logic [ndsaw_pkg::DataW-1:0] pwdata,
  output logic [ndsaw_pkg::DataW-1:0] prdata,
  output ndsaw_pkg::walk_cfg_t        cfg_o
);
  import ndsaw_pkg::*;

  logic [NumDims-1:0][SizeW-1:0] size_q, size_d;
  logic [NumDims-1:0][StepW-1:0] step_q, step_d;
  logic [NumDims-1:0][OfsW-1:0]  wrap_q, wrap_d;
  logic [NumDims-1:0][ProdW-1:0] prod;
  logic                          wr_en;
  cfg_reg_e                      reg_sel;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = cfg_reg_e'(paddr[AddrW-1:2]);

  always_comb begin
    size_d = size_q;
    step_d = step_q;
    if (wr_en) begin
      unique case (reg_sel)
        RegSizeDim0: size_d[0] = pwdata[SizeW-1:0];
        RegSizeDim1: size_d[1] = pwdata[SizeW-1:0];
        RegSizeDim2: size_d[2] = pwdata[SizeW-1:0];
        RegSizeDim3: size_d[3] = pwdata[SizeW-1:0];
        RegStepDim0: step_d[0] = pwdata[StepW-1:0];
        RegStepDim1: step_d[1] = pwdata[StepW-1:0];
        RegStepDim2: step_d[2] = pwdata[StepW-1:0];
        RegStepDim3: step_d[3] = pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int d = 0; d < NumDims; d++) begin
      prod[d]   = ProdW'(step_d[d]) * ProdW'(eff_size(size_d[d]));
      wrap_d[d] = OfsW'(step_d[d]) - OfsW'(prod[d]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < NumDims; d++) begin
        size_q[d] <= SizeW'(1);
        step_q[d] <= StepW'(1);
        wrap_q[d] <= '0;
      end
    end else begin
      size_q <= size_d;
      step_q <= step_d;
      wrap_q <= wrap_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      RegSizeDim0: prdata = DataW'(size_q[0]);
      RegSizeDim1: prdata = DataW'(size_q[1]);
      RegSizeDim2: prdata = DataW'(size_q[2]);
      RegSizeDim3: prdata = DataW'(size_q[3]);
      RegStepDim0: prdata = DataW'(step_q[0]);
      RegStepDim1: prdata = DataW'(step_q[1]);
      RegStepDim2: prdata = DataW'(step_q[2]);
      RegStepDim3: prdata = DataW'(step_q[3]);
      default: prdata = '0;
    endcase
  end

  always_comb begin
    for (int d = 0; d < NumDims; d++) begin
      cfg_o.size[d] = eff_size(size_q[d]);
    end
    cfg_o.step = step_q;
    cfg_o.wrap = wrap_q;
  end

endmodule

// ===== rtl/nd_strided_address_walker_unit.sv =====
// ----------------------------------------------------------------------------
// nd_strided_address_walker_unit
// Walks an up to four-dimensional strided source array in dense order and
// issues one source offset and destination index per request.
// ----------------------------------------------------------------------------
// Usage:
//   Program sizes and steps over the APB port while no request is pending.
//   Each request on the input channel (in_valid_i / in_stall_o) carries a
//   restart bit and yields exactly one result on the output channel
//   (out_valid_o / out_stall_i): src_offset_o, dst_index_o and last_o.
//   The result is registered and valid in the cycle after acceptance. Throughput is one
//   request per cycle while the receiver does not stall, set by the single odometer
//   update between the walk state registers and the result register.
//   After last_o the walk returns to element zero by itself.
//   Reset clears the walk, sets all sizes and steps to one and empties the
//   result register. While the receiver stalls a held result, in_stall_o is
//   high; a result taken in the same cycle frees room for the next request.
//   A config write reaches the walk on the next cycle.
// ----------------------------------------------------------------------------
module nd_strided_address_walker_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ndsaw_pkg::AddrW-1:0] paddr,
  input  logic [ndsaw_pkg::DataW-1:0] pwdata,
  output logic [ndsaw_pkg::DataW-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        restart_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ndsaw_pkg::OfsW-1:0]  src_offset_o,
  output logic [ndsaw_pkg::IdxW-1:0]  dst_index_o,
  output logic                        last_o
);
  import ndsaw_pkg::*;

  walk_cfg_t                     cfg;
  logic [NumDims-1:0][CntW-1:0]  cnt_q, cnt_d, cnt_cur;
  logic [OfsW-1:0]               ofs_q, ofs_d, ofs_cur, ofs_add;
  logic [IdxW-1:0]               idx_q, idx_d, idx_cur;
  logic [NumDims-1:0]            at_end;
  logic [NumDims:0]              carry;
  logic                          is_last;
  logic                          in_accept;
  logic                          out_valid_q;
  logic [OfsW-1:0]               res_ofs_q;
  logic [IdxW-1:0]               res_idx_q;
  logic                          res_last_q;

  ndsaw_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .cfg_o  (cfg)
  );

  assign pready     = 1'b1;
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_comb begin
    cnt_cur = restart_i ? '0 : cnt_q;
    ofs_cur = restart_i ? '0 : ofs_q;
    idx_cur = restart_i ? '0 : idx_q;
    for (int d = 0; d < NumDims; d++) begin
      at_end[d] = ({1'b0, cnt_cur[d]} + SizeW'(1)) >= cfg.size[d];
    end
    carry[0] = 1'b1;
    for (int d = 0; d < NumDims; d++) begin
      carry[d+1] = carry[d] & at_end[d];
    end
    is_last = carry[NumDims];
    ofs_add = '0;
    for (int d = 0; d < NumDims; d++) begin
      if (carry[d]) begin
        ofs_add = ofs_add + (at_end[d] ? cfg.wrap[d] : OfsW'(cfg.step[d]));
      end
    end
    for (int d = 0; d < NumDims; d++) begin
      cnt_d[d] = cnt_cur[d];
      if (carry[d]) begin
        cnt_d[d] = at_end[d] ? '0 : cnt_cur[d] + CntW'(1);
      end
    end
    ofs_d = ofs_cur + ofs_add;
    idx_d = idx_cur + IdxW'(1);
    if (is_last) begin
      cnt_d = '0;
      ofs_d = '0;
      idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ofs_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        cnt_q <= cnt_d;
        ofs_q <= ofs_d;
        idx_q <= idx_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_ofs_q  <= ofs_cur;
      res_idx_q  <= idx_cur;
      res_last_q <= is_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign src_offset_o = res_ofs_q;
  assign dst_index_o  = res_idx_q;
  assign last_o       = res_last_q;

`ifndef SYNTHESIS
  a_wrap_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_last) |=> (ofs_q == '0 && idx_q == '0 && cnt_q == '0))
    else $error("walk not cleared after last element");

  a_index_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !is_last) |=> (idx_q == $past(idx_cur) + IdxW'(1)))
    else $error("destination index did not advance by one");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (out_valid_o && dst_index_o == $past(idx_cur)))
    else $error("accepted request has no matching result");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the strided address walker. A scoreboard keeps its
// own odometer of the walk and predicts offset, index and end flag for every
// accepted request. The bench runs directed settings first (all sizes one,
// a small four-dimensional array with restarts, oversized dimensions), then
// random walk settings that are reprogrammed mid-walk. Both channels idle at
// random, and one long output hold backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  import ndsaw_pkg::*;

  localparam int unsigned HoldCycles   = 150;
  localparam int unsigned QuietLimit   = 5000;
  localparam int unsigned RandomTarget = 1000;

  typedef struct packed {
    logic [OfsW-1:0] src;
    logic [IdxW-1:0] dst;
    logic            last;
  } walk_res_t;

  class walk_scoreboard;
    logic [SizeW-1:0] size_raw [NumDims];
    logic [StepW-1:0] step_raw [NumDims];
    int unsigned      pos [NumDims];
    logic [OfsW-1:0]  ofs;
    logic [IdxW-1:0]  idx;
    walk_res_t        due_q [$];
    int unsigned      n_bad;
    int unsigned      n_checked;
    int unsigned      n_last;
    int unsigned      n_req;
    int unsigned      n_restart;

    function new();
      for (int d = 0; d < NumDims; d++) begin
        size_raw[d] = SizeW'(1);
        step_raw[d] = StepW'(1);
      end
      n_bad = 0;
      n_checked = 0;
      n_last = 0;
      n_req = 0;
      n_restart = 0;
      rewind();
    endfunction

    function void rewind();
      for (int d = 0; d < NumDims; d++) begin
        pos[d] = 0;
      end
      ofs = '0;
      idx = '0;
    endfunction

    function int unsigned extent(int d);
      int unsigned s;
      s = size_raw[d];
      if (s == 0) begin
        return 1;
      end
      if (s > 4096) begin
        return 4096;
      end
      return s;
    endfunction

    function void write_reg(cfg_reg_e r, logic [DataW-1:0] data);
      if (int'(r) < NumDims) begin
        size_raw[int'(r)] = data[SizeW-1:0];
      end else begin
        step_raw[int'(r) - NumDims] = data[StepW-1:0];
      end
    endfunction

    function void note_request(logic restart);
      walk_res_t       want;
      bit              at_end;
      int unsigned     sz;
      logic [OfsW-1:0] st;
      n_req++;
      if (restart) begin
        n_restart++;
        rewind();
      end
      at_end = 1'b1;
      for (int d = 0; d < NumDims; d++) begin
        if (pos[d] + 1 < extent(d)) at_end = 1'b0;
      end
      want.src  = ofs;
      want.dst  = idx;
      want.last = at_end;
      due_q.push_back(want);
      if (at_end) begin
        rewind();
      end else begin
        idx = idx + 1'b1;
        for (int d = 0; d < NumDims; d++) begin
          sz  = extent(d);
          st  = OfsW'(step_raw[d]);
          ofs = ofs + st;
          if (pos[d] + 1 < sz) begin
            pos[d]++;
            break;
          end
          pos[d] = 0;
          ofs = ofs - st * OfsW'(sz);
        end
      end
    endfunction

    function void check_result(logic [OfsW-1:0] src, logic [IdxW-1:0] dst, logic last);
      walk_res_t want;
      if (due_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("unexpected result: src=%h dst=%h last=%b", src, dst, last);
        end
        return;
      end
      want = due_q.pop_front();
      n_checked++;
      if (want.last) n_last++;
      if (src !== want.src || dst !== want.dst || last !== want.last) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("mismatch on result %0d: expected src=%h dst=%h last=%b,",
                   n_checked, want.src, want.dst, want.last);
          $display("  got src=%h dst=%h last=%b", src, dst, last);
        end
      end
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             restart_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [OfsW-1:0]  src_offset_o;
  logic [IdxW-1:0]  dst_index_o;
  logic             last_o;

  walk_scoreboard   sb = new();
  bit               calm;
  bit               hold_req;
  int unsigned      hold_left;
  int unsigned      quiet_cycles = 0;
  int unsigned      n_settings;
  int unsigned      n_random;
  logic [SizeW-1:0] plan_size [NumDims];
  logic [StepW-1:0] plan_step [NumDims];

  nd_strided_address_walker_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .src_offset_o (src_offset_o),
    .dst_index_o  (dst_index_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(src_offset_o, dst_index_o, last_o);
      if (in_valid_i && !in_stall_o) sb.note_request(restart_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no traffic for %0d cycles", quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stalls, one long hold on request
  initial begin
    out_stall_i = 1'b0;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 10);
      end
      @(posedge clk_i);
    end
  end

  task automatic apb_write(input cfg_reg_e r, input logic [DataW-1:0] value);
    logic [DataW-1:0] data;
    data = $urandom;
    if (int'(r) < NumDims) begin
      data[SizeW-1:0] = value[SizeW-1:0];
    end else begin
      data[StepW-1:0] = value[StepW-1:0];
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * int'(r));
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_reg(r, data);
  endtask

  task automatic program_walk();
    for (int i = 0; i < 2 * NumDims; i++) begin
      if (i < NumDims) begin
        apb_write(cfg_reg_e'(i), DataW'(plan_size[i]));
      end else begin
        apb_write(cfg_reg_e'(i), DataW'(plan_step[i - NumDims]));
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  task automatic pick_walk_plan();
    for (int d = 0; d < NumDims; d++) begin
      case ($urandom_range(0, 15))
        0: plan_size[d] = '0;
        1: plan_size[d] = MaxSize;
        2: plan_size[d] = SizeW'($urandom_range(4097, 8191));
        3: plan_size[d] = SizeW'($urandom_range(7, 40));
        default: plan_size[d] = SizeW'($urandom_range(1, (d < 2) ? 6 : 3));
      endcase
      case ($urandom_range(0, 7))
        0: plan_step[d] = '0;
        1: plan_step[d] = '1;
        2: plan_step[d] = StepW'($urandom_range(1, 4));
        default: plan_step[d] = StepW'($urandom);
      endcase
    end
  endtask

  task automatic offer(input logic r);
    int unsigned gap;
    if (!calm && $urandom_range(0, 99) < 4) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        in_valid_i <= 1'b0;
        restart_i  <= 1'($urandom_range(0, 1));
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    restart_i  <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic finish_phase();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned pct, input bit lead);
    logic r;
    for (int unsigned i = 0; i < n; i++) begin
      r = (i == 0 && lead) ? 1'b1 : ($urandom_range(0, 99) < pct);
      offer(r);
    end
    finish_phase();
  endtask

  initial begin
    int unsigned n;
    int unsigned pct;
    bit          lead;
    int unsigned phase_no;
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    restart_i  = 1'b0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    n_settings = 0;
    n_random   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sizes: every request is its own last element
    offer(1'b0);
    offer(1'b1);
    offer(1'b0);
    finish_phase();

    plan_size = '{SizeW'(2), SizeW'(3), SizeW'(0), SizeW'(2)};
    plan_step = '{StepW'(24'hFFFFFF), StepW'(3), StepW'(0), StepW'(1000)};
    program_walk();
    repeat (13) offer(1'b0);
    repeat (3) offer(1'b0);
    offer(1'b1);
    repeat (2) offer(1'b0);
    finish_phase();

    plan_size = '{MaxSize, SizeW'(8191), SizeW'(1), SizeW'(1)};
    plan_step = '{StepW'(1), StepW'(24'hFFFFFF), StepW'(0), StepW'(0)};
    program_walk();
    repeat (3) offer(1'b0);
    finish_phase();

    // random settings, reprogrammed without restart so walks change mid-way
    phase_no = 0;
    while (n_random < RandomTarget) begin
      pick_walk_plan();
      program_walk();
      calm = (phase_no % 6 == 4);
      lead = 1'($urandom_range(0, 1));
      pct  = ($urandom_range(0, 4) == 0) ? 50 : 3;
      n    = $urandom_range(20, 120);
      if (phase_no == 3) begin
        hold_req = 1'b1;
        n = 100;
      end
      run_phase(n, pct, lead);
      n_random += n;
      phase_no++;
    end
    calm = 1'b0;

    repeat (4) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0d results never arrived", sb.pending());
      sb.n_bad += sb.pending();
    end
    $display("walked %0d requests (%0d restarts) over %0d register settings",
             sb.n_req, sb.n_restart, n_settings);
    $display("checked %0d results, %0d at end of array, %0d mismatches",
             sb.n_checked, sb.n_last, sb.n_bad);
    if (sb.n_bad == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== nd_strided_address_walker_unit.f =====
rtl/ndsaw_pkg.sv
rtl/ndsaw_cfg.sv
rtl/nd_strided_address_walker_unit.sv
dv/tb_top.sv
